// ===== hw/rtl/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

  localparam int unsigned FractionBits = 8;
  localparam int unsigned DataW        = 32;
  localparam int unsigned ProdW        = 2 * DataW;
  // Rounded dividend 2*(|a| << F) + |b| stays below 2^(DataW+F+1).
  localparam int unsigned NumW         = DataW + FractionBits + 2;
  localparam int unsigned DenW         = DataW + 1;
  localparam int unsigned NumCells     = NumW;

  localparam logic signed [DataW-1:0] RawMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] RawMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    FIN_DIRECT,
    FIN_MUL,
    FIN_DIV
  } fin_e;

  typedef struct packed {
    logic [3:0]              kind;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic                    compare_true;
    logic                    overflow;
    logic                    divide_by_zero;
  } out_t;

  // Sideband that rides along the divider chain.
  typedef struct packed {
    fin_e                    fin;
    logic                    neg;
    logic signed [ProdW-1:0] prod;
    logic signed [DataW-1:0] result;
    logic                    cmp;
    logic                    ovf;
    logic                    dz;
  } side_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DenW-1:0] den;
    logic [NumW-1:0] num;
    logic [NumW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] value;
  } sat_t;

  // Saturate a sign and magnitude pair to the raw range.
  function automatic sat_t sat_mag(logic [ProdW-1:0] mag, logic neg);
    sat_t s;
    s.ovf   = 1'b0;
    s.value = '0;
    if (!neg) begin
      if (mag > ProdW'(RawMax)) begin
        s.ovf   = 1'b1;
        s.value = RawMax;
      end else begin
        s.value = mag[DataW-1:0];
      end
    end else begin
      if (mag > {{(ProdW-DataW){1'b0}}, RawMin}) begin
        s.ovf   = 1'b1;
        s.value = RawMin;
      end else begin
        s.value = (~mag[DataW-1:0]) + DataW'(1);
      end
    end
    return s;
  endfunction

  // Saturate a signed wide value to the raw range.
  function automatic sat_t sat_wide(logic signed [ProdW-1:0] x);
    sat_t s;
    s.ovf   = 1'b0;
    s.value = x[DataW-1:0];
    if (x > ProdW'(RawMax)) begin
      s.ovf   = 1'b1;
      s.value = RawMax;
    end else if (x < $signed({{(ProdW-DataW){1'b1}}, RawMin})) begin
      s.ovf   = 1'b1;
      s.value = RawMin;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fpa_pre.sv =====
`default_nettype none

module fpa_pre (
  input  fpa_pkg::in_t  data_i,
  output fpa_pkg::side_t side_o,
  output fpa_pkg::div_t  div_o
);
  import fpa_pkg::*;

  logic signed [DataW-1:0] a, b;
  logic [DataW-1:0]        mag_a, mag_b, trunc;
  logic signed [DataW:0]   sum, diff;
  logic signed [ProdW-1:0] wide_a, wide_b;
  sat_t                    sat;

  assign a      = data_i.operand_a;
  assign b      = data_i.operand_b;
  assign mag_a  = a[DataW-1] ? DataW'(-a) : a;
  assign mag_b  = b[DataW-1] ? DataW'(-b) : b;
  assign sum    = {a[DataW-1], a} + {b[DataW-1], b};
  assign diff   = {a[DataW-1], a} - {b[DataW-1], b};
  assign wide_a = ProdW'(a);
  assign wide_b = ProdW'(b);
  assign trunc  = mag_a >> FractionBits;

  always_comb begin
    side_o        = '0;
    side_o.fin    = FIN_DIRECT;
    side_o.prod   = wide_a * wide_b;
    side_o.neg    = a[DataW-1] ^ b[DataW-1];
    div_o.rem     = '0;
    div_o.quo     = '0;
    div_o.den     = {mag_b, 1'b0};
    div_o.num     = (NumW'(mag_a) << (FractionBits + 1)) + NumW'(mag_b);
    sat           = '0;
    case (op_e'(data_i.kind))
      OP_ADD: begin
        sat           = sat_wide(ProdW'(sum));
        side_o.result = sat.value;
        side_o.ovf    = sat.ovf;
      end
      OP_SUB: begin
        sat           = sat_wide(ProdW'(diff));
        side_o.result = sat.value;
        side_o.ovf    = sat.ovf;
      end
      OP_MUL: side_o.fin = FIN_MUL;
      OP_DIV: begin
        if (b == '0) begin
          side_o.dz     = 1'b1;
          side_o.result = (a == '0) ? '0 : (a[DataW-1] ? RawMin : RawMax);
        end else begin
          side_o.fin = FIN_DIV;
        end
      end
      OP_GT:  side_o.cmp = (a > b);
      OP_LT:  side_o.cmp = (a < b);
      OP_GE:  side_o.cmp = (a >= b);
      OP_LE:  side_o.cmp = (a <= b);
      OP_EQ:  side_o.cmp = (a == b);
      OP_NE:  side_o.cmp = (a != b);
      OP_MIN: side_o.result = (a < b) ? a : b;
      OP_MAX: side_o.result = (a > b) ? a : b;
      OP_INC: begin
        side_o.ovf    = (a == RawMax);
        side_o.result = (a == RawMax) ? RawMax : a + DataW'(1);
      end
      OP_DEC: begin
        side_o.ovf    = (a == RawMin);
        side_o.result = (a == RawMin) ? RawMin : a - DataW'(1);
      end
      OP_FROM_INT: begin
        sat           = sat_wide(wide_a <<< FractionBits);
        side_o.result = sat.value;
        side_o.ovf    = sat.ovf;
      end
      default: begin
        side_o.result = a[DataW-1] ? DataW'(-trunc) : trunc;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpa_div_cell.sv =====
`default_nettype none

module fpa_div_cell (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            en_i,
  input  wire            valid_i,
  input  fpa_pkg::side_t side_i,
  input  fpa_pkg::div_t  div_i,
  output logic           valid_o,
  output fpa_pkg::side_t side_o,
  output fpa_pkg::div_t  div_o
);
  import fpa_pkg::*;

  logic          valid_q;
  side_t         side_q;
  div_t          div_q, div_d;
  logic [DenW:0] trial;
  logic          take;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {div_i.rem, div_i.num[NumW-1]};
  assign take  = (trial >= {1'b0, div_i.den});

  always_comb begin
    div_d     = div_i;
    div_d.rem = take ? DenW'(trial - {1'b0, div_i.den}) : trial[DenW-1:0];
    div_d.num = {div_i.num[NumW-2:0], 1'b0};
    div_d.quo = {div_i.quo[NumW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fpa_post.sv =====
`default_nettype none

module fpa_post (
  input  fpa_pkg::side_t side_i,
  input  fpa_pkg::div_t  div_i,
  output fpa_pkg::out_t  data_o
);
  import fpa_pkg::*;

  localparam logic [ProdW-1:0] Half = ProdW'(1) << (FractionBits - 1);

  logic             prod_neg;
  logic [ProdW-1:0] rounded;
  sat_t             sat;

  // Round the product magnitude: h - p for negative p, p + h otherwise.
  assign prod_neg = side_i.prod[ProdW-1];
  assign rounded  = (prod_neg ? (Half - side_i.prod) : (side_i.prod + Half)) >> FractionBits;

  always_comb begin
    data_o.compare_true   = side_i.cmp;
    data_o.divide_by_zero = side_i.dz;
    sat                   = '0;
    case (side_i.fin)
      FIN_MUL: begin
        sat                 = sat_mag(rounded, prod_neg);
        data_o.result_value = sat.value;
        data_o.overflow     = sat.ovf;
      end
      FIN_DIV: begin
        sat                 = sat_mag(ProdW'(div_i.quo), side_i.neg);
        data_o.result_value = sat.value;
        data_o.overflow     = sat.ovf;
      end
      default: begin
        data_o.result_value = side_i.result;
        data_o.overflow     = side_i.ovf;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_point_q24_8_alu.sv =====
// A result is registered in the front stage, each divider cell and the output register in turn.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The divider is a row of NumCells restoring cells, one quotient bit per cell.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data regs keep content.
`default_nettype none

module fixed_point_q24_8_alu (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output fpa_pkg::out_t out_data_o
);
  import fpa_pkg::*;

  // Advance every stage when the output register is free or being drained.
  logic  en;
  logic  front_valid_q;
  side_t front_side_q, front_side_d;
  div_t  front_div_q, front_div_d;

  logic  chain_valid [NumCells+1];
  side_t chain_side  [NumCells+1];
  div_t  chain_div   [NumCells+1];

  logic  out_valid_q;
  out_t  out_data_q, out_data_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Decode, simple ops, multiply and divider setup.
  fpa_pre u_pre (
    .data_i (in_data_i),
    .side_o (front_side_d),
    .div_o  (front_div_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (en) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_side_q <= front_side_d;
      front_div_q  <= front_div_d;
    end
  end

  assign chain_valid[0] = front_valid_q;
  assign chain_side[0]  = front_side_q;
  assign chain_div[0]   = front_div_q;

  // Divider row: every item passes through all cells, whatever its operation.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .side_i  (chain_side[i]),
      .div_i   (chain_div[i]),
      .valid_o (chain_valid[i+1]),
      .side_o  (chain_side[i+1]),
      .div_o   (chain_div[i+1])
    );
  end

  // Round multiply results, saturate multiply and divide results, pass the rest through.
  fpa_post u_post (
    .side_i (chain_side[NumCells]),
    .div_i  (chain_div[NumCells]),
    .data_o (out_data_d)
  );

  // Hold the result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam int unsigned NumRandom = 1550;
  localparam int unsigned Latency   = NumCells + 2;
  localparam longint      CycleCap  = 400000;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_data_o;

  fixed_point_q24_8_alu i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Results still owed by the block, oldest first.
  out_t   alu_results_due[$];
  int     mismatch_count;
  longint cycle_count;
  bit     long_hold_req;  // sender asks the receiver for one long stall

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Saturate a 64-bit signed value to the raw range.
  function automatic out_t clamp_raw(longint x);
    out_t o;
    o = '0;
    if (x > longint'(RawMax)) begin
      o.result_value = RawMax;
      o.overflow     = 1'b1;
    end else if (x < longint'(RawMin)) begin
      o.result_value = RawMin;
      o.overflow     = 1'b1;
    end else begin
      o.result_value = x[DataW-1:0];
    end
    return o;
  endfunction

  // Compute what the ALU returns for one operation, in exact integers.
  function automatic out_t alu_result(in_t it);
    longint     a;
    longint     b;
    longint     prod;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    bit         neg;
    out_t       o;
    a = longint'(it.operand_a);
    b = longint'(it.operand_b);
    o = '0;
    case (op_e'(it.kind))
      OP_ADD: o = clamp_raw(a + b);
      OP_SUB: o = clamp_raw(a - b);
      OP_MUL: begin
        prod = a * b;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'd1 << (FractionBits - 1))) >> FractionBits;
        o    = clamp_raw((prod < 0) ? -longint'(mag) : longint'(mag));
      end
      OP_DIV: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
          o.result_value   = (a > 0) ? RawMax : ((a < 0) ? RawMin : '0);
        end else begin
          num = ((a < 0) ? -a : a) << FractionBits;
          den = (b < 0) ? -b : b;
          quo = (2 * num + den) / (2 * den);
          neg = (a < 0) != (b < 0);
          o   = clamp_raw(neg ? -longint'(quo) : longint'(quo));
        end
      end
      OP_GT: o.compare_true = a > b;
      OP_LT: o.compare_true = a < b;
      OP_GE: o.compare_true = a >= b;
      OP_LE: o.compare_true = a <= b;
      OP_EQ: o.compare_true = a == b;
      OP_NE: o.compare_true = a != b;
      OP_MIN: o.result_value = (a < b) ? it.operand_a : it.operand_b;
      OP_MAX: o.result_value = (a > b) ? it.operand_a : it.operand_b;
      OP_INC: o = clamp_raw(a + 1);
      OP_DEC: o = clamp_raw(a - 1);
      OP_FROM_INT: o = clamp_raw(a * (longint'(1) << FractionBits));
      default: begin
        // Truncate toward zero: shift the magnitude, then restore the sign.
        mag = (a < 0) ? -a : a;
        mag = mag >> FractionBits;
        o.result_value = 32'((a < 0) ? -longint'(mag) : longint'(mag));
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // Directed rows: typed expectation only where it is obvious at a glance.
  typedef struct {
    op_e         kind;
    logic [31:0] a;
    logic [31:0] b;
    bit          has_want;
    out_t        want;
  } row_t;

  row_t directed_rows[$];

  task automatic add_row(op_e k, logic [31:0] a, logic [31:0] b, bit has, out_t w);
    row_t r;
    r.kind = k; r.a = a; r.b = b; r.has_want = has; r.want = w;
    directed_rows.push_back(r);
  endtask

  function automatic out_t mk(logic [31:0] v, bit c, bit ov, bit dz);
    out_t o;
    o.result_value = v; o.compare_true = c; o.overflow = ov; o.divide_by_zero = dz;
    return o;
  endfunction

  // Random operand, skewed toward the extremes and small values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return RawMax - $urandom_range(0, 3);
      1:       return RawMin + $urandom_range(0, 3);
      2:       return 32'($signed($urandom_range(0, 2048)) - 1024);
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transfer and hold it until the block takes it.
  task automatic send_item(in_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    alu_results_due.push_back(alu_result(it));
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    in_data_i  <= in_t'({$urandom, $urandom, $urandom});
  endtask

  // Sender: directed table, then random bursts with gaps.
  initial begin : sender
    in_t it;
    int  burst;
    int  gap;
    int  n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    long_hold_req = 1'b0;
    add_row(OP_ADD, RawMax, 32'd1, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_ADD, RawMin, 32'hFFFFFFFF, 1, mk(RawMin, 0, 1, 0));
    add_row(OP_SUB, RawMin, 32'd1, 1, mk(RawMin, 0, 1, 0));
    add_row(OP_SUB, RawMax, RawMin, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_MUL, RawMax, RawMax, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_MUL, RawMin, RawMin, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_MUL, 32'h1, 32'h80, 0, '0);     // rounding tie away from zero
    add_row(OP_MUL, 32'hFFFFFFFF, 32'h80, 0, '0);
    add_row(OP_DIV, 32'd5, 32'd0, 1, mk(RawMax, 0, 0, 1));
    add_row(OP_DIV, 32'hFFFFFFFB, 32'd0, 1, mk(RawMin, 0, 0, 1));
    add_row(OP_DIV, 32'd0, 32'd0, 1, mk('0, 0, 0, 1));
    add_row(OP_DIV, RawMin, 32'hFFFFFFFF, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_DIV, RawMax, 32'd1, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_DIV, 32'd1, 32'd3, 0, '0);
    add_row(OP_GT, RawMax, RawMin, 1, mk('0, 1, 0, 0));
    add_row(OP_LT, RawMax, RawMin, 1, mk('0, 0, 0, 0));
    add_row(OP_GE, 32'd7, 32'd7, 1, mk('0, 1, 0, 0));
    add_row(OP_LE, RawMin, RawMax, 1, mk('0, 1, 0, 0));
    add_row(OP_EQ, RawMin, RawMin, 1, mk('0, 1, 0, 0));
    add_row(OP_NE, RawMin, RawMin, 1, mk('0, 0, 0, 0));
    add_row(OP_MIN, RawMin, RawMax, 1, mk(RawMin, 0, 0, 0));
    add_row(OP_MAX, RawMin, RawMax, 1, mk(RawMax, 0, 0, 0));
    add_row(OP_INC, RawMax, 32'd0, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_DEC, RawMin, 32'd0, 1, mk(RawMin, 0, 1, 0));
    add_row(OP_FROM_INT, 32'h00800000, 32'd0, 1, mk(RawMax, 0, 1, 0));
    add_row(OP_TO_INT, 32'hFFFFFF01, 32'd0, 1, mk('0, 0, 0, 0));
    add_row(OP_TO_INT, RawMin, RawMax, 1, mk(32'hFF800000, 0, 0, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      it.kind      = directed_rows[i].kind;
      it.operand_a = directed_rows[i].a;
      it.operand_b = directed_rows[i].b;
      send_item(it);
      // Typed expectation replaces the computed one; mismatch means the predictor drifted.
      if (directed_rows[i].has_want) begin
        if (alu_results_due[$] != directed_rows[i].want)
          report_mismatch("directed row predictor", i, -1);
        alu_results_due[$] = directed_rows[i].want;
      end
    end
    drop_valid();

    // Pause until every expected result has drained.
    while (alu_results_due.size() != 0) @(posedge clk_i);

    n = 0;
    while (n < NumRandom) begin
      burst = $urandom_range(1, 40);
      // Partway through, ask for a long receiver stall and keep offering.
      if (n >= 600 && !long_hold_req) begin
        long_hold_req = 1'b1;
        burst         = 120;
      end
      for (int k = 0; k < burst && n < NumRandom; k++) begin
        it.kind      = 4'($urandom);
        it.operand_a = pick_operand();
        it.operand_b = ($urandom_range(0, 15) == 0) ? '0 : pick_operand();
        send_item(it);
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        drop_valid();
        repeat (gap) @(posedge clk_i);
      end
    end
    drop_valid();

    while (alu_results_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatch_count == 0 && alu_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: stall pattern, stretches of full speed, and one long hold.
  initial begin : receiver
    int hold_left;
    bit long_done;
    out_ready_i = 1'b0;
    long_done   = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_done) begin
        long_done = 1'b1;
        hold_left = 3 * Latency;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if ((cycle_count / 200) % 3 == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alu_results_due.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.result_value, 0);
      end else begin
        want = alu_results_due.pop_front();
        if (out_data_o.result_value !== want.result_value)
          report_mismatch("result_value", out_data_o.result_value, want.result_value);
        if (out_data_o.compare_true !== want.compare_true)
          report_mismatch("compare_true", out_data_o.compare_true, want.compare_true);
        if (out_data_o.overflow !== want.overflow)
          report_mismatch("overflow", out_data_o.overflow, want.overflow);
        if (out_data_o.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", out_data_o.divide_by_zero,
                          want.divide_by_zero);
      end
    end
  end

  // Abort a hung run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleCap) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// ===== fixed_point_q24_8_alu.f =====
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_pre.sv
hw/rtl/fpa_div_cell.sv
hw/rtl/fpa_post.sv
hw/rtl/fixed_point_q24_8_alu.sv
sim/tb.sv
